@@ rtl/averaged_divider_ohmmeter_unit_defines.svh @@
// ============================================================================
// Averaged divider ohmmeter assertion macros
// Shared concurrent assertion forms for the ohmmeter checker.
// ============================================================================
`ifndef AVERAGED_DIVIDER_OHMMETER_UNIT_DEFINES_SVH
`define AVERAGED_DIVIDER_OHMMETER_UNIT_DEFINES_SVH

// same-cycle implication
`define ADOM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ohmmeter same-cycle check failed");

// next-cycle implication
`define ADOM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ohmmeter next-cycle check failed");

`endif

@@ rtl/adom_pkg.sv @@
// ============================================================================
// Averaged divider ohmmeter package
// Field widths, status and register codes, sequencer states.
// ============================================================================
package adom_pkg;

    localparam int ADC_W     = 12;
    localparam int SUM_W     = 17;
    localparam int CNT_W     = 6;
    localparam int REG_W     = 20;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RREF0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RREF1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [REG_W-1:0] RST_RREF0 = 20'd10540;
    localparam logic [REG_W-1:0] RST_RREF1 = 20'd10430;
    localparam logic [REG_W-1:0] RST_LIMIT = 20'd100000;

    typedef enum logic [STAT_W-1:0] {
        RS_SHORT  = 2'd0,
        RS_NORMAL = 2'd1,
        RS_OVER   = 2'd2
    } t_range_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

endpackage

@@ rtl/adom_div.sv @@
// ============================================================================
// Averaged divider ohmmeter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module adom_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/averaged_divider_ohmmeter_unit.sv @@
// ============================================================================
// Averaged divider ohmmeter
// A sample that does not complete an average is accumulated without stalling.
// A completing sample passes S_MUL and S_CMP, then the 37-step restoring
// divider on rref*sum, or goes straight to S_OUT when open or over range;
// the input stalls until that result is loaded, output stalls extending it.
// Synchronous active-low reset clears sums, counts, sequencer and output valid.
// ============================================================================
module averaged_divider_ohmmeter_unit #(
    parameter int NUM_SAMPLES    = 20,
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_channel,
    input  logic [adom_pkg::ADC_W-1:0]       i_adc_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_result_channel,
    output logic [adom_pkg::REG_W-1:0]       o_resistance_ohms,
    output logic [adom_pkg::STAT_W-1:0]      o_range_status,
    input  logic                             i_cfg_we,
    input  logic [adom_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adom_pkg::REG_W-1:0]       i_cfg_data
);
    import adom_pkg::*;

    localparam int NF    = NUM_SAMPLES * ADC_FULL_SCALE;
    localparam int NF_W  = $clog2(NF + 1);
    localparam int CMP_W = (NF_W > SUM_W) ? NF_W : SUM_W;
    localparam int NUM_W = REG_W + SUM_W;
    localparam int DEN_W = NF_W;
    localparam int LIM_W = REG_W + DEN_W;
    localparam int PRD_W = (LIM_W > NUM_W) ? LIM_W : NUM_W;

    localparam logic [CMP_W-1:0] NF_V    = CMP_W'(NF);
    localparam logic [CMP_W-1:0] OPEN_TH = CMP_W'(NUM_SAMPLES * (ADC_FULL_SCALE - 1));
    localparam logic [CNT_W-1:0] N_V     = CNT_W'(NUM_SAMPLES);

    t_state          r_state;
    t_state          n_state;
    logic [SUM_W-1:0] r_sum [2];
    logic [CNT_W-1:0] r_cnt [2];
    logic [REG_W-1:0] r_rref0;
    logic [REG_W-1:0] r_rref1;
    logic [REG_W-1:0] r_limit;
    logic             r_ch;
    logic [SUM_W-1:0] r_sum_hold;
    logic             r_open;
    logic [NUM_W-1:0] r_num;
    logic [LIM_W-1:0] r_lim;
    logic [DEN_W-1:0] r_den;
    logic [REG_W-1:0] r_ohms;
    logic [REG_W-1:0] n_ohms;
    t_range_status    r_stat;
    t_range_status    n_stat;
    logic             r_out_valid;
    logic             r_out_ch;
    logic [REG_W-1:0] r_out_ohms;
    t_range_status    r_out_stat;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_div_start;
    logic             w_div_done;
    logic [NUM_W-1:0] w_quot;
    logic [SUM_W-1:0] w_sum_new;
    logic [CNT_W-1:0] w_cnt_new;
    logic             w_full;
    logic [REG_W-1:0] w_rref;
    logic [CMP_W-1:0] w_den_full;
    logic             w_over;

    always_comb begin
        w_in_acc   = i_in_valid && (r_state == S_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_sum_new  = r_sum[i_channel] + SUM_W'(i_adc_sample);
        w_cnt_new  = r_cnt[i_channel] + 1'b1;
        w_full     = w_cnt_new >= N_V;
        w_rref     = r_ch ? r_rref1 : r_rref0;
        w_den_full = NF_V - CMP_W'(r_sum_hold);
        w_over     = PRD_W'(r_num) > PRD_W'(r_lim);
    end

    always_comb begin
        n_state     = r_state;
        n_ohms      = r_ohms;
        n_stat      = r_stat;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_full) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_open || w_over) begin
                    n_ohms  = '0;
                    n_stat  = RS_OVER;
                    n_state = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_ohms  = w_quot[REG_W-1:0];
                    n_stat  = (w_quot == '0) ? RS_SHORT : RS_NORMAL;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_rref0     <= RST_RREF0;
            r_rref1     <= RST_RREF1;
            r_limit     <= RST_LIMIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (w_full) begin
                    r_sum[i_channel] <= '0;
                    r_cnt[i_channel] <= '0;
                end else begin
                    r_sum[i_channel] <= w_sum_new;
                    r_cnt[i_channel] <= w_cnt_new;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RREF0) begin
                    r_rref0 <= i_cfg_data;
                end else if (i_cfg_index == CFG_RREF1) begin
                    r_rref1 <= i_cfg_data;
                end else if (i_cfg_index == CFG_LIMIT) begin
                    r_limit <= i_cfg_data;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ohms <= n_ohms;
        r_stat <= n_stat;
        if (w_in_acc && w_full) begin
            r_ch       <= i_channel;
            r_sum_hold <= w_sum_new;
            r_open     <= CMP_W'(w_sum_new) >= OPEN_TH;
        end
        if (r_state == S_MUL) begin
            r_num <= NUM_W'(w_rref) * NUM_W'(r_sum_hold);
            r_den <= w_den_full[DEN_W-1:0];
            r_lim <= LIM_W'(r_limit) * LIM_W'(w_den_full[DEN_W-1:0]);
        end
        if (w_out_load) begin
            r_out_ch   <= r_ch;
            r_out_ohms <= r_ohms;
            r_out_stat <= r_stat;
        end
    end

    adom_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_result_channel  = r_out_ch;
    assign o_resistance_ohms = r_out_ohms;
    assign o_range_status    = r_out_stat;

endmodule

@@ rtl/adom_chk.sv @@
// ============================================================================
// Averaged divider ohmmeter checker
// Port-level checks on result coding and held requests, bound to the top.
// ============================================================================
`include "averaged_divider_ohmmeter_unit_defines.svh"

module adom_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_result_channel,
    input logic [adom_pkg::REG_W-1:0]   o_resistance_ohms,
    input logic [adom_pkg::STAT_W-1:0]  o_range_status
);
    import adom_pkg::*;

    `ADOM_ASSERT_IMP(a_stat_code, i_clk, i_rst_n, o_out_valid, o_range_status == RS_SHORT || o_range_status == RS_NORMAL || o_range_status == RS_OVER)
    `ADOM_ASSERT_IMP(a_zero_ohms, i_clk, i_rst_n, o_out_valid && o_range_status != RS_NORMAL, o_resistance_ohms == '0)
    `ADOM_ASSERT_IMP(a_normal_nz, i_clk, i_rst_n, o_out_valid && o_range_status == RS_NORMAL, o_resistance_ohms != '0)
    `ADOM_ASSERT_NXT(a_hold_req, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_resistance_ohms) && $stable(o_range_status) && $stable(o_result_channel))

endmodule

bind averaged_divider_ohmmeter_unit adom_chk u_adom_chk (.*);
